// ===== rtl/dual_connection_table_match_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual connection table
// Short forms for clocked, reset-qualified implication checks.
// ----------------------------------------------------------------------------
`ifndef DUAL_CONNECTION_TABLE_MATCH_ASSERT_SVH
`define DUAL_CONNECTION_TABLE_MATCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCTM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCTM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dctm_pkg.sv =====
// ----------------------------------------------------------------------------
// dctm_pkg
// Word types, action codes and constants of the dual connection table.
// ----------------------------------------------------------------------------
package dctm_pkg;

  // Action codes of a request word.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  // A low byte of exactly this value asks for a free entry.
  localparam logic [7:0] FREE_MARK = 8'o200;
  localparam logic [7:0] LOW_BYTE  = 8'o377;

  // Bit of the host-link word that picks the write table.
  localparam int TABLE_BIT = 7;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] host_link;
    logic [15:0] socket_ref;
    logic        entry_table;
    logic [4:0]  entry_slot;
    logic        entry_present;
  } req_t;

  typedef struct packed {
    logic       found;
    logic       hit_table;
    logic [4:0] hit_slot;
  } rsp_t;

  // One connection entry; a zero key marks it free.
  typedef struct packed {
    logic [15:0] key;
    logic [15:0] sock;
  } entry_t;

  // One memory row holds the same slot of both tables.
  typedef entry_t [1:0] row_t;

endpackage

// ===== rtl/dual_connection_table_match.sv =====
// ----------------------------------------------------------------------------
// dual_connection_table_match
// Read and write connection tables with insert, lookup and remove.
// ----------------------------------------------------------------------------
// A request word enters on req when req_valid is high and req_stall is low;
// each request gives exactly one response word on rsp, taken when rsp_valid
// is high and rsp_stall is low. The block works on one request at a time and
// holds req_stall high from acceptance until the response has been loaded
// into the output register.
// Insert and lookup scan the chosen table one slot per cycle through a
// single memory read port and one shared key and socket comparator. The scan
// stops at the first matching slot, or on a miss after the last slot, and the
// result goes through S_DONE into the output register. A remove of a slot in
// range reads and writes one row in S_RM_RD and S_RM_WR; any other remove and
// an unused action go straight to S_DONE. The next request is accepted in the
// cycle after the response is loaded, even while the receiver still stalls it.
// If the receiver stalls, a finished response waits in the output register
// and a following result waits in the sequencer until that register frees.
// Reset clears the per-slot valid flags at once, so every entry reads as
// free and zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dual_connection_table_match #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dctm_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output dctm_pkg::rsp_t rsp
);
  import dctm_pkg::*;

  localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = SW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_RM_RD = 3'd2;
  localparam logic [2:0] S_RM_WR = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]          state;
  req_t                cur;
  logic [15:0]         skey;
  logic [15:0]         ssock;
  logic                stab;
  logic [CW-1:0]       rd_addr;
  logic                cmp_on;
  logic [SW-1:0]       cmp_addr;
  rsp_t                res;

  row_t                mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid;
  row_t                rd_row;
  logic                rd_vld;

  logic                rd_en;
  logic [SW-1:0]       rd_idx;
  logic                mem_we;
  logic [SW-1:0]       wr_idx;
  row_t                wr_row;
  row_t                eff_row;
  entry_t              cur_ent;
  logic                match;
  logic                last;
  logic                more;
  logic                req_rm_ok;
  logic                out_free;
  logic                accept;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_rm_ok = req.entry_present && (32'(req.entry_slot) < TABLE_DEPTH);

  // A row never written since reset reads as all zero.
  assign eff_row = rd_vld ? rd_row : '0;
  assign cur_ent = eff_row[stab];

  // Shared comparator: key always, socket only when a tag is given.
  assign match = (cur_ent.key == skey) && ((ssock == '0) || (cur_ent.sock == ssock));
  assign last  = (cmp_addr == SW'(TABLE_DEPTH - 1));
  assign more  = (rd_addr < CW'(TABLE_DEPTH));

  // Read port address and enable.
  always_comb begin
    rd_en  = 1'b0;
    rd_idx = rd_addr[SW-1:0];
    if (state == S_RM_RD) begin
      rd_en  = 1'b1;
      rd_idx = SW'(cur.entry_slot);
    end else if (state == S_SCAN) begin
      rd_en = more;
    end
  end

  // Write port: insert into the hit slot, or clear the key on remove.
  always_comb begin
    mem_we = 1'b0;
    wr_idx = cmp_addr;
    wr_row = eff_row;
    if (state == S_SCAN && cmp_on && match && cur.action == ACT_INSERT) begin
      mem_we            = 1'b1;
      wr_row[stab].key  = cur.host_link;
      wr_row[stab].sock = cur.socket_ref;
    end else if (state == S_RM_WR) begin
      mem_we                       = 1'b1;
      wr_idx                       = SW'(cur.entry_slot);
      wr_row[cur.entry_table].key  = '0;
    end
  end

  // Table memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= wr_row;
    end
    if (rd_en) begin
      rd_row <= mem[rd_idx];
      rd_vld <= valid[rd_idx];
    end
  end

  // Per-slot valid flags, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (mem_we) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  // Request latch; payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur  <= req;
      stab <= req.host_link[TABLE_BIT];
      if (req.action == ACT_LOOKUP) begin
        skey  <= ((req.host_link & {8'h00, LOW_BYTE}) == {8'h00, FREE_MARK}) ?
                 16'h0000 : req.host_link;
        ssock <= req.socket_ref;
      end else begin
        skey  <= '0;
        ssock <= '0;
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_addr  <= '0;
      cmp_on   <= 1'b0;
      cmp_addr <= '0;
      res      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            rd_addr <= '0;
            cmp_on  <= 1'b0;
            case (req.action)
              ACT_INSERT, ACT_LOOKUP: begin
                state <= S_SCAN;
              end
              ACT_REMOVE: begin
                res.found     <= 1'b1;
                res.hit_table <= req.entry_table;
                res.hit_slot  <= req.entry_slot;
                state         <= req_rm_ok ? S_RM_RD : S_DONE;
              end
              default: begin
                res   <= '0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (cmp_on && match) begin
            res.found     <= 1'b1;
            res.hit_table <= stab;
            res.hit_slot  <= 5'(cmp_addr);
            state         <= S_DONE;
          end else if (cmp_on && last) begin
            res.found     <= 1'b0;
            res.hit_table <= stab;
            res.hit_slot  <= '0;
            state         <= S_DONE;
          end else if (more) begin
            rd_addr  <= rd_addr + CW'(1);
            cmp_addr <= rd_addr[SW-1:0];
            cmp_on   <= 1'b1;
          end
        end
        S_RM_RD: begin
          state <= S_RM_WR;
        end
        S_RM_WR: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp <= res;
    end
  end

`include "dual_connection_table_match_assert.svh"

  `DCTM_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, state != S_IDLE, "idle after accept")
  `DCTM_ASSERT_NEXT(a_done_loads, clk, rst, state == S_DONE && out_free, rsp_valid, "no word")
  `DCTM_ASSERT_SAME(a_scan_bound, clk, rst, state == S_SCAN, rd_addr <= CW'(TABLE_DEPTH), "scan overrun")
  `DCTM_ASSERT_SAME(a_miss_zero, clk, rst, rsp_valid && !rsp.found, rsp.hit_slot == 5'd0, "miss slot")

endmodule
